// File: rtl/core/kmce_pkg.sv
package kmce_pkg;

    localparam int ROWS    = 5;
    localparam int COLUMNS = 6;

    localparam int ROW_W   = 3;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int LEVEL_W = 6;
    localparam int KEY_W   = 5;
    localparam int CNT_W   = 3;
    localparam int LIMIT_W = 8;

    localparam int MASKS_W  = 30;
    localparam int COUNTS_W = 15;
    localparam int CFG_W    = 30;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MASKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT  = 2'd2;

    localparam logic [MASKS_W-1:0]  MASKS_RESET  = 30'h3FFF_FFFF;
    localparam logic [COUNTS_W-1:0] COUNTS_RESET = 15'd28086;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd32;

    // event kinds
    localparam logic EVT_PRESS   = 1'b0;
    localparam logic EVT_RELEASE = 1'b1;

    // one classified row sample, front to back
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COLUMNS-1:0] pressed;
        logic [COLUMNS-1:0] released;
        logic               scan_start;
    } row_entry_t;

    // configuration seen by the front
    typedef struct packed {
        logic [MASKS_W-1:0]  valid_masks;
        logic [COUNTS_W-1:0] column_counts;
    } front_cfg_t;

endpackage

// File: rtl/core/kmce_front.sv
module kmce_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kmce_pkg::front_cfg_t         cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [kmce_pkg::ROW_W-1:0]   s_row_index,
    input  logic [kmce_pkg::LEVEL_W-1:0] s_column_levels,
    input  logic                         s_scan_start,
    output logic                         push,
    output kmce_pkg::row_entry_t         push_entry,
    input  logic                         queue_full
);
    import kmce_pkg::*;

    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [COLUMNS-1:0] row_state_reg [ROWS];
    logic [COLUMNS-1:0] row_state_next;

    logic               in_range;
    logic [RIDX_W-1:0]  row_sel;
    logic [CNT_W-1:0]   count_raw;
    logic [CNT_W-1:0]   count_sat;
    logic [COLUMNS-1:0] scanned;
    logic [COLUMNS-1:0] levels;
    logic [COLUMNS-1:0] prev_bits;
    logic [COLUMNS-1:0] valid;
    logic [COLUMNS-1:0] prev_m;
    logic [COLUMNS-1:0] curr_m;
    logic [COLUMNS-1:0] changed;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // row lookup and column count saturation
    always_comb begin
        in_range  = (s_row_index < ROW_W'(ROWS));
        row_sel   = in_range ? RIDX_W'(s_row_index) : '0;
        count_raw = cfg.column_counts[row_sel*CNT_W +: CNT_W];
        count_sat = (count_raw > CNT_W'(COLUMNS)) ? CNT_W'(COLUMNS) : count_raw;
        for (int c = 0; c < COLUMNS; c++) begin
            scanned[c] = (c < int'(count_sat));
        end
        levels    = COLUMNS'(s_column_levels);
        prev_bits = row_state_reg[row_sel];
        row_state_next = (prev_bits & ~scanned) | (~levels & scanned);
        valid     = cfg.valid_masks[row_sel*COLUMNS +: COLUMNS];
    end

    // classify changes against the valid mask
    always_comb begin
        prev_m  = prev_bits & valid;
        curr_m  = row_state_next & valid;
        changed = prev_m ^ curr_m;
        push_entry.row        = s_row_index;
        push_entry.scan_start = s_scan_start;
        push_entry.pressed    = in_range ? (changed & curr_m) : '0;
        push_entry.released   = in_range ? (changed & prev_m) : '0;
    end

    // row store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                row_state_reg[r] <= '0;
            end
        end else if (push && in_range) begin
            row_state_reg[row_sel] <= row_state_next;
        end
    end

endmodule

// File: rtl/core/kmce_queue.sv
module kmce_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  kmce_pkg::row_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output kmce_pkg::row_entry_t head_entry
);
    import kmce_pkg::*;

    row_entry_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QPTR_W:0]       fill_reg;
    logic [QPTR_W:0]       fill_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty  = (fill_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/kmce_back.sv
module kmce_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [kmce_pkg::LIMIT_W-1:0] event_limit,
    input  logic                         q_not_empty,
    input  kmce_pkg::row_entry_t         q_head,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_key_event,
    output logic [kmce_pkg::KEY_W-1:0]   m_key_id,
    output logic                         m_last_event
);
    import kmce_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [ROW_W-1:0]     row_reg;
    logic [COLUMNS-1:0]   press_reg;
    logic [COLUMNS-1:0]   press_next;
    logic [COLUMNS-1:0]   rel_reg;
    logic [COLUMNS-1:0]   rel_next;
    logic [LIMIT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0]   count_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 key_event_reg;
    logic [KEY_W-1:0]     key_id_reg;
    logic                 last_event_reg;

    logic                 slot_free;
    logic                 limit_hit;
    logic                 emit;
    logic                 use_press;
    logic [COLUMNS-1:0]   bits;
    logic [COL_W-1:0]     col;
    logic [COLUMNS-1:0]   rem_press;
    logic [COLUMNS-1:0]   rem_rel;
    logic [LIMIT_W:0]     count_inc;
    logic                 is_last;
    logic [KEY_W-1:0]     key_id_calc;

    assign slot_free = !m_valid_reg || m_ready;
    assign limit_hit = (count_reg >= event_limit);
    assign emit      = busy_reg && slot_free && !limit_hit;
    assign q_pop     = !busy_reg && q_not_empty;

    // pick lowest pending column, presses before releases
    always_comb begin
        use_press = (press_reg != '0);
        bits      = use_press ? press_reg : rel_reg;
        col       = '0;
        for (int c = COLUMNS - 1; c >= 0; c--) begin
            if (bits[c]) begin
                col = COL_W'(c);
            end
        end
        rem_press = press_reg;
        rem_rel   = rel_reg;
        if (use_press) begin
            rem_press[col] = 1'b0;
        end else begin
            rem_rel[col] = 1'b0;
        end
        count_inc   = {1'b0, count_reg} + 1'b1;
        is_last     = ((rem_press == '0) && (rem_rel == '0)) ||
                      (count_inc >= {1'b0, event_limit});
        key_id_calc = KEY_W'(row_reg) * KEY_W'(COLUMNS) + KEY_W'(col);
    end

    // sequencing of the current entry
    always_comb begin
        busy_next    = busy_reg;
        press_next   = press_reg;
        rel_next     = rel_reg;
        count_next   = count_reg;
        m_valid_next = slot_free ? 1'b0 : m_valid_reg;
        if (busy_reg) begin
            if (limit_hit) begin
                busy_next = 1'b0;
            end else if (slot_free) begin
                m_valid_next = 1'b1;
                press_next   = rem_press;
                rel_next     = rem_rel;
                count_next   = count_inc[LIMIT_W-1:0];
                if (is_last) begin
                    busy_next = 1'b0;
                end
            end
        end else if (q_not_empty) begin
            press_next = q_head.pressed;
            rel_next   = q_head.released;
            busy_next  = (q_head.pressed != '0) || (q_head.released != '0);
            if (q_head.scan_start) begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // entry payload and output word
    always_ff @(posedge aclk) begin
        press_reg <= press_next;
        rel_reg   <= rel_next;
        if (q_pop) begin
            row_reg <= q_head.row;
        end
        if (emit) begin
            key_event_reg  <= use_press ? EVT_PRESS : EVT_RELEASE;
            key_id_reg     <= key_id_calc;
            last_event_reg <= is_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_event  = key_event_reg;
    assign m_key_id     = key_id_reg;
    assign m_last_event = last_event_reg;

endmodule

// File: rtl/core/key_matrix_change_events.sv
// Key matrix change detector. Each input word is one sampled row (active-low
// column levels); the front compares it with the stored row in the same
// cycle, updates the row store and queues the press and release masks in a
// four-entry queue. The back end takes one entry at a time, only once it is
// through with the previous one, and returns its events one per cycle while
// the result side accepts them; a stalled result side holds it. Input is
// stalled only while the queue is full. Events past the event limit within
// one scan are dropped, and last_event marks the final event returned for a
// row. Configuration writes complete at once and are meant for idle periods.
module key_matrix_change_events (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kmce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kmce_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kmce_pkg::ROW_W-1:0]     s_row_index,
    input  logic [kmce_pkg::LEVEL_W-1:0]   s_column_levels,
    input  logic                           s_scan_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_key_event,
    output logic [kmce_pkg::KEY_W-1:0]     m_key_id,
    output logic                           m_last_event
);
    import kmce_pkg::*;

    logic [MASKS_W-1:0]  masks_reg;
    logic [COUNTS_W-1:0] counts_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    front_cfg_t          front_cfg;
    logic                push;
    row_entry_t          push_entry;
    logic                queue_full;
    logic                q_pop;
    logic                q_not_empty;
    row_entry_t          q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            masks_reg  <= MASKS_RESET;
            counts_reg <= COUNTS_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_VALID_MASKS:  masks_reg  <= cfg_data[MASKS_W-1:0];
                REG_COLUMN_COUNT: counts_reg <= cfg_data[COUNTS_W-1:0];
                REG_EVENT_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.valid_masks   = masks_reg;
    assign front_cfg.column_counts = counts_reg;

    kmce_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (front_cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_index     (s_row_index),
        .s_column_levels (s_column_levels),
        .s_scan_start    (s_scan_start),
        .push            (push),
        .push_entry      (push_entry),
        .queue_full      (queue_full)
    );

    kmce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (q_head)
    );

    kmce_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .event_limit  (limit_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_event  (m_key_event),
        .m_key_id     (m_key_id),
        .m_last_event (m_last_event)
    );

endmodule

// File: test/key_matrix_change_events_tb.sv
`timescale 1ns / 1ps

module key_matrix_change_events_tb;
    import kmce_pkg::*;

    // index past the register list, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int NUM_DIRECTED  = 21;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_WORDS   = 28;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_AT_WORD  = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_FROM    = 220;
    localparam int QUIET_TO      = 270;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] id;
        logic             last;
    } key_evt_t;

    // one row sample, with an optional hand-written expectation
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        logic               start;
        logic               typed;
        logic               has_evt;
        logic               kind;
        logic [KEY_W-1:0]   id;
    } row_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [ROW_W-1:0]     s_row_index;
    logic [LEVEL_W-1:0]   s_column_levels;
    logic                 s_scan_start;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_key_event;
    logic [KEY_W-1:0]     m_key_id;
    logic                 m_last_event;

    key_matrix_change_events u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_index     (s_row_index),
        .s_column_levels (s_column_levels),
        .s_scan_start    (s_scan_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_event     (m_key_event),
        .m_key_id        (m_key_id),
        .m_last_event    (m_last_event)
    );

    // predictor copy of registers and state
    logic [MASKS_W-1:0]  cfg_masks;
    logic [COUNTS_W-1:0] cfg_counts;
    logic [LIMIT_W-1:0]  cfg_limit;
    logic [COLUMNS-1:0]  held_keys [ROWS];
    logic [LIMIT_W-1:0]  scan_events;

    key_evt_t  row_events [COLUMNS];
    int        row_event_cnt;
    key_evt_t  pending_events [$];
    row_word_t directed_rows [NUM_DIRECTED];
    logic [LEVEL_W-1:0] scan_levels [ROWS];

    int fails;
    int words_in;
    int cycle_count;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic idle_roll();
        if (words_in >= QUIET_FROM && words_in < QUIET_TO) return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    // store update and press/release events of one row sample
    task automatic predict_row_events(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] lev,
                                      input logic st);
        int                 ncols;
        logic [COLUMNS-1:0] scanned;
        logic [COLUMNS-1:0] old_bits;
        logic [COLUMNS-1:0] new_bits;
        logic [COLUMNS-1:0] vmask;
        logic [COLUMNS-1:0] pressed;
        logic [COLUMNS-1:0] released;
        row_event_cnt = 0;
        if (st) scan_events = '0;
        if (r >= ROWS) return;
        ncols = int'(cfg_counts[r*CNT_W +: CNT_W]);
        if (ncols > COLUMNS) ncols = COLUMNS;
        scanned = COLUMNS'((1 << ncols) - 1);
        old_bits = held_keys[r];
        new_bits = (old_bits & ~scanned) | (~lev & scanned);
        held_keys[r] = new_bits;
        vmask = cfg_masks[r*COLUMNS +: COLUMNS];
        old_bits &= vmask;
        new_bits &= vmask;
        pressed = new_bits & ~old_bits;
        released = old_bits & ~new_bits;
        // presses first, then releases, both lowest column first
        for (int c = 0; c < COLUMNS; c++) begin
            if (pressed[c] && scan_events < cfg_limit) begin
                row_events[row_event_cnt] = '{EVT_PRESS, KEY_W'(r * COLUMNS + c), 1'b0};
                row_event_cnt++;
                scan_events++;
            end
        end
        for (int c = 0; c < COLUMNS; c++) begin
            if (released[c] && scan_events < cfg_limit) begin
                row_events[row_event_cnt] = '{EVT_RELEASE, KEY_W'(r * COLUMNS + c), 1'b0};
                row_event_cnt++;
                scan_events++;
            end
        end
        if (row_event_cnt > 0) row_events[row_event_cnt-1].last = 1'b1;
    endtask

    // offer one row word, queue its events once accepted
    task automatic send_word(input row_word_t w);
        if (idle_roll()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_roll());
        end
        s_valid         <= 1'b1;
        s_row_index     <= w.row;
        s_column_levels <= w.levels;
        s_scan_start    <= w.start;
        do @(posedge aclk); while (!s_ready);
        words_in++;
        predict_row_events(w.row, w.levels, w.start);
        if (w.typed) begin
            if (w.has_evt) pending_events.push_back('{w.kind, w.id, 1'b1});
        end else begin
            for (int k = 0; k < row_event_cnt; k++) pending_events.push_back(row_events[k]);
        end
    endtask

    // register write, valid is lowered by the caller after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_VALID_MASKS:  cfg_masks  = data[MASKS_W-1:0];
            REG_COLUMN_COUNT: cfg_counts = data[COUNTS_W-1:0];
            REG_EVENT_LIMIT:  cfg_limit  = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // wait for all events, then for anything still in flight
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic setup_phase(input int p);
        case (p)
            // high bits set beyond the count and limit registers, counts saturate, widest limit
            0: begin
                write_reg(REG_VALID_MASKS, MASKS_RESET);
                write_reg(REG_COLUMN_COUNT, 30'h3FFF_FFFF);
                write_reg(REG_EVENT_LIMIT, 30'h3FFF_FFFF);
            end
            // no key valid and limit zero
            1: begin
                write_reg(REG_EVENT_LIMIT, '0);
                write_reg(REG_VALID_MASKS, '0);
            end
            // no columns scanned
            2: begin
                write_reg(REG_VALID_MASKS, MASKS_RESET);
                write_reg(REG_COLUMN_COUNT, '0);
                write_reg(REG_EVENT_LIMIT, CFG_W'(LIMIT_RESET));
            end
            3: begin
                write_reg(REG_VALID_MASKS, CFG_W'($urandom));
                write_reg(REG_COLUMN_COUNT, CFG_W'($urandom));
                write_reg(REG_EVENT_LIMIT, CFG_W'(1));
            end
            4: begin
                write_reg(REG_UNUSED, CFG_W'($urandom));
                write_reg(REG_COLUMN_COUNT, CFG_W'(COUNTS_RESET));
                write_reg(REG_EVENT_LIMIT, CFG_W'(3));
                write_reg(REG_VALID_MASKS, CFG_W'($urandom) | CFG_W'($urandom));
            end
            default: begin
                write_reg(REG_VALID_MASKS,
                          ($urandom_range(3) == 0) ? CFG_W'(MASKS_RESET) : CFG_W'($urandom));
                write_reg(REG_COLUMN_COUNT, CFG_W'($urandom));
                write_reg(REG_EVENT_LIMIT,
                          ($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(40)));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // full scan with a few keys toggled per row
    task automatic send_scan();
        row_word_t          w;
        logic [LEVEL_W-1:0] flips;
        for (int r = 0; r < ROWS; r++) begin
            if ($urandom_range(9) == 0) begin
                flips = LEVEL_W'($urandom);
            end else begin
                for (int b = 0; b < LEVEL_W; b++) flips[b] = ($urandom_range(5) == 0);
            end
            scan_levels[r] = scan_levels[r] ^ flips;
            w = '0;
            w.row = ROW_W'(r);
            w.levels = scan_levels[r];
            w.start = (r == 0);
            send_word(w);
        end
    endtask

    task automatic run_phase();
        row_word_t w;
        int        n;
        n = 0;
        while (n < PHASE_WORDS) begin
            if ($urandom_range(9) < 8) begin
                send_scan();
                n += ROWS;
            end else begin
                // stray word: any row, any levels, random scan mark
                w = '0;
                w.row = ROW_W'($urandom_range(7));
                w.levels = LEVEL_W'($urandom);
                w.start = ($urandom_range(3) == 0);
                send_word(w);
                if (w.row < ROWS) n++;
            end
        end
    endtask

    // result side: ready pattern and checking
    initial begin
        key_evt_t exp_evt;
        int       hold_left;
        logic     held;
        hold_left = 0;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    $error("key event with none expected: key_id %0d", m_key_id);
                    fails++;
                end else begin
                    exp_evt = pending_events.pop_front();
                    if (m_key_event !== exp_evt.kind) begin
                        $error("key_event: expected %0d, got %0d", exp_evt.kind, m_key_event);
                        fails++;
                    end
                    if (m_key_id !== exp_evt.id) begin
                        $error("key_id: expected %0d, got %0d", exp_evt.id, m_key_id);
                        fails++;
                    end
                    if (m_last_event !== exp_evt.last) begin
                        $error("last_event: expected %0d, got %0d", exp_evt.last, m_last_event);
                        fails++;
                    end
                end
            end
            // one long hold so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && words_in >= HOLD_AT_WORD) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_roll();
            end
        end
    end

    // stimulus
    initial begin
        fails = 0;
        words_in = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_row_index = '0;
        s_column_levels = '1;
        s_scan_start = 1'b0;
        cfg_masks = MASKS_RESET;
        cfg_counts = COUNTS_RESET;
        cfg_limit = LIMIT_RESET;
        scan_events = '0;
        for (int r = 0; r < ROWS; r++) begin
            held_keys[r] = '0;
            scan_levels[r] = '1;
        end

        // row, levels, start, typed, has event, kind, key id
        directed_rows[0]  = {3'd0, 6'b111110, 1'b1, 1'b1, 1'b1, EVT_PRESS,   5'd0};
        directed_rows[1]  = {3'd0, 6'b111111, 1'b0, 1'b1, 1'b1, EVT_RELEASE, 5'd0};
        directed_rows[2]  = {3'd4, 6'b011111, 1'b0, 1'b1, 1'b1, EVT_PRESS,   5'd29};
        directed_rows[3]  = {3'd4, 6'b111111, 1'b0, 1'b1, 1'b1, EVT_RELEASE, 5'd29};
        directed_rows[4]  = {3'd0, 6'b000000, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[5]  = {3'd0, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[6]  = {3'd1, 6'b101010, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[7]  = {3'd1, 6'b010101, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        // rows past the matrix, one with a scan mark
        directed_rows[8]  = {3'd5, 6'b000000, 1'b0, 1'b1, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[9]  = {3'd7, 6'b000000, 1'b1, 1'b1, 1'b0, EVT_PRESS,   5'd0};
        // unchanged row
        directed_rows[10] = {3'd2, 6'b111111, 1'b0, 1'b1, 1'b0, EVT_PRESS,   5'd0};
        // fill the scan past the limit of 32 events
        directed_rows[11] = {3'd3, 6'b000000, 1'b1, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[12] = {3'd2, 6'b000000, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[13] = {3'd4, 6'b000000, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[14] = {3'd3, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[15] = {3'd2, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[16] = {3'd4, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[17] = {3'd1, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        // new scan restarts the count
        directed_rows[18] = {3'd1, 6'b000000, 1'b1, 1'b0, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[19] = {3'd6, 6'b101010, 1'b0, 1'b1, 1'b0, EVT_PRESS,   5'd0};
        directed_rows[20] = {3'd1, 6'b111111, 1'b0, 1'b0, 1'b0, EVT_PRESS,   5'd0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) send_word(directed_rows[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            setup_phase(p);
            run_phase();
            drain();
        end

        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
